### hw/rtl/aavr_pkg.sv
package aavr_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned TableLen    = 24;
  localparam int unsigned UsedSteps   = (CordicSteps > TableLen) ? TableLen : CordicSteps;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueueAw     = $clog2(QueueDepth);

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusZero = 2'd1;
  localparam logic [1:0] StatusSat  = 2'd2;

  localparam logic signed [33:0] OneQ30  = 34'sd1073741824;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic [15:0]        angle_phase;
    logic               zero_axis;
  } item_t;

  function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
    logic signed [33:0] r;
    case (idx)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // q30 product with round half up, floor shift
  function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + 68'sd536870912;
    return 34'(p >>> 30);
  endfunction

  function automatic logic signed [33:0] clamp_one(input logic signed [34:0] v);
    logic signed [33:0] r;
    if (v > 35'(OneQ30)) r = OneQ30;
    else if (v < -35'(OneQ30)) r = -OneQ30;
    else r = 34'(v);
    return r;
  endfunction

endpackage

### hw/rtl/axis_angle_vector_rotate.sv
// axis-angle rotation of a q16.16 vector, one per cycle unless stalled
// input channel: in_valid/in_ready with vec, axis and angle_phase fields
// output channel: out_valid/out_ready with rot fields and status
// status 0 ok, 1 zero axis (vector passed through), 2 saturated
// front: 4-entry queue that flags a zero axis on entry
// back: fully pipelined datapath from queue to result
//   magnitude and shift, sum of squares, 32-stage square root,
//   32-stage divide for the unit axis, 16-stage cordic alongside,
//   then products, matrix and dot products
// throughput: one transaction per cycle when the receiver keeps up
// when the receiver stalls the whole back pipeline freezes and the
// queue absorbs up to four transactions before in_ready drops
// reset clears the queue and all valid bits; nothing is in flight after
module axis_angle_vector_rotate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  vec_x_i,
  input  logic signed [31:0]  vec_y_i,
  input  logic signed [31:0]  vec_z_i,
  input  logic signed [31:0]  axis_x_i,
  input  logic signed [31:0]  axis_y_i,
  input  logic signed [31:0]  axis_z_i,
  input  logic [15:0]         angle_phase_i,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  rot_x_o,
  output logic signed [31:0]  rot_y_o,
  output logic signed [31:0]  rot_z_o,
  output logic [1:0]          status_o
);
  import aavr_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;

  aavr_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready,
    .vec_x_i, .vec_y_i, .vec_z_i, .axis_x_i, .axis_y_i, .axis_z_i, .angle_phase_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  aavr_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid, .out_ready, .rot_x_o, .rot_y_o, .rot_z_o, .status_o
  );

endmodule

### hw/rtl/aavr_front.sv
module aavr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   vec_x_i,
  input  logic signed [31:0]   vec_y_i,
  input  logic signed [31:0]   vec_z_i,
  input  logic signed [31:0]   axis_x_i,
  input  logic signed [31:0]   axis_y_i,
  input  logic signed [31:0]   axis_z_i,
  input  logic [15:0]          angle_phase_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output aavr_pkg::item_t      q_item_o
);
  import aavr_pkg::*;

  item_t               mem_q [QueueDepth];
  logic [QueueAw-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QueueAw:0]    cnt_q, cnt_d;
  logic                push, pop;
  item_t               in_item;

  always_comb begin
    in_item.vec_x       = vec_x_i;
    in_item.vec_y       = vec_y_i;
    in_item.vec_z       = vec_z_i;
    in_item.axis_x      = axis_x_i;
    in_item.axis_y      = axis_y_i;
    in_item.axis_z      = axis_z_i;
    in_item.angle_phase = angle_phase_i;
    in_item.zero_axis   = (axis_x_i == '0) && (axis_y_i == '0) && (axis_z_i == '0);
  end

  assign in_ready  = (cnt_q != (QueueAw+1)'(QueueDepth));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_q];
  assign push      = in_valid && in_ready;
  assign pop       = q_valid_o && q_ready_i;
  assign wr_d      = push ? wr_q + 1'b1 : wr_q;
  assign rd_d      = pop ? rd_q + 1'b1 : rd_q;
  assign cnt_d     = cnt_q + (QueueAw+1)'(push) - (QueueAw+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QueueAw+1)'(QueueDepth)) else $error("queue count overflow");
  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (QueueAw+1)'(QueueDepth)) |-> !push) else $error("push into full queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count not tracking");

endmodule

### hw/rtl/aavr_back.sv
module aavr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  aavr_pkg::item_t     q_item_i,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  rot_x_o,
  output logic signed [31:0]  rot_y_o,
  output logic signed [31:0]  rot_z_o,
  output logic [1:0]          status_o
);
  import aavr_pkg::*;

  // pipeline: 0 mag/shift, 1 sum squares, 2..33 isqrt (2 bits per stage x 32),
  // then 3 divide groups of 32 stages each in parallel, then matrix and dot products
  localparam int unsigned SqSteps  = 32;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned SU       = 2 + SqSteps + DivSteps;

  typedef struct packed {
    logic               vld;
    item_t              it;
    logic [2:0]         neg;
    logic [2:0][31:0]   mag;
    logic [63:0]        rem;
    logic [63:0]        root;
    logic [32:0]        len;
    logic [2:0][63:0]   drem;
    logic [2:0][31:0]   quo;
  } pipe_t;

  pipe_t st_q [SU];
  pipe_t st_d [SU];
  logic  adv;

  // downstream holding register
  logic               ov_q;
  logic signed [31:0] rx_q, ry_q, rz_q;
  logic [1:0]         rs_q;

  assign adv       = !ov_q || out_ready;
  assign q_ready_o = adv;

  always_comb begin
    logic [63:0] big;
    logic [5:0]  k;
    logic [63:0] m0, m1, m2;
    for (int s = 0; s < SU; s++) st_d[s] = st_q[s];
    // stage 0: capture magnitudes, normalize shift
    st_d[0]     = '0;
    st_d[0].vld = q_valid_i;
    st_d[0].it  = q_item_i;
    st_d[0].neg = {q_item_i.axis_z[31], q_item_i.axis_y[31], q_item_i.axis_x[31]};
    m0 = q_item_i.axis_x[31] ? 64'(-33'(q_item_i.axis_x)) : 64'(q_item_i.axis_x);
    m1 = q_item_i.axis_y[31] ? 64'(-33'(q_item_i.axis_y)) : 64'(q_item_i.axis_y);
    m2 = q_item_i.axis_z[31] ? 64'(-33'(q_item_i.axis_z)) : 64'(q_item_i.axis_z);
    big = m0;
    if (m1 > big) big = m1;
    if (m2 > big) big = m2;
    k = '0;
    for (int b = 0; b < 31; b++) begin
      if (big[b]) k = 6'(30 - b);
    end
    if (big[31] || big[32]) k = '0;
    st_d[0].mag[0] = 32'(m0 << k);
    st_d[0].mag[1] = 32'(m1 << k);
    st_d[0].mag[2] = 32'(m2 << k);
    // stage 1: sum of squares
    st_d[1]     = st_q[0];
    st_d[1].rem = 64'(st_q[0].mag[0]) * 64'(st_q[0].mag[0])
                + 64'(st_q[0].mag[1]) * 64'(st_q[0].mag[1])
                + 64'(st_q[0].mag[2]) * 64'(st_q[0].mag[2]);
    st_d[1].root = '0;
    // isqrt, one result bit per stage
    for (int s = 0; s < SqSteps; s++) begin
      logic [63:0] bt, tr;
      st_d[2+s] = st_q[1+s];
      bt = 64'(1) << (62 - 2*s);
      tr = st_q[1+s].root + bt;
      if (st_q[1+s].rem >= tr) begin
        st_d[2+s].rem  = st_q[1+s].rem - tr;
        st_d[2+s].root = (st_q[1+s].root >> 1) + bt;
      end else begin
        st_d[2+s].root = st_q[1+s].root >> 1;
      end
    end
    // divide setup + restoring steps (quotient capped at 32 bits useful)
    for (int s = 0; s < DivSteps; s++) begin
      pipe_t p;
      p = st_q[1+SqSteps+s];
      if (s == 0) begin
        p.len = 33'(p.root);
        for (int a = 0; a < 3; a++) begin
          p.drem[a] = (64'(p.mag[a]) << 30) + 64'(p.len >> 1);
          p.quo[a]  = '0;
        end
      end
      for (int a = 0; a < 3; a++) begin
        logic [63:0] dv;
        dv = 64'(p.len) << (DivSteps - 1 - s);
        if (p.drem[a] >= dv) begin
          p.drem[a] = p.drem[a] - dv;
          p.quo[a]  = p.quo[a] | (32'(1) << (DivSteps - 1 - s));
        end
      end
      st_d[2+SqSteps+s] = p;
    end
  end

  // cordic chain runs alongside the first UsedSteps stages
  logic signed [33:0] cx0, cy0, cz0;
  logic               cf0;

  always_comb begin
    logic signed [16:0] p;
    p = 17'(signed'(q_item_i.angle_phase));
    cf0 = 1'b0;
    if (p > 17'sd16384) begin p = p - 17'sd32768; cf0 = 1'b1; end
    else if (p < -17'sd16384) begin p = p + 17'sd32768; cf0 = 1'b1; end
    cx0 = CordicGain;
    cy0 = '0;
    cz0 = 34'(p) <<< 16;
  end

  logic signed [33:0] cx_q [UsedSteps];
  logic signed [33:0] cy_q [UsedSteps];
  logic signed [33:0] cz_q [UsedSteps];
  logic               cf_q [UsedSteps];

  for (genvar i = 0; i < UsedSteps; i++) begin : g_cordic
    logic signed [33:0] xi, yi, zi;
    logic               fi;
    if (i == 0) begin : g_first
      assign xi = cx0;
      assign yi = cy0;
      assign zi = cz0;
      assign fi = cf0;
    end else begin : g_next
      assign xi = cx_q[i-1];
      assign yi = cy_q[i-1];
      assign zi = cz_q[i-1];
      assign fi = cf_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!zi[33]) begin
          cx_q[i] <= xi - (yi >>> i);
          cy_q[i] <= yi + (xi >>> i);
          cz_q[i] <= zi - atan_turn(5'(i));
        end else begin
          cx_q[i] <= xi + (yi >>> i);
          cy_q[i] <= yi - (xi >>> i);
          cz_q[i] <= zi + atan_turn(5'(i));
        end
        cf_q[i] <= fi;
      end
    end
  end

  // cordic result delay to align with divider output
  localparam int unsigned CAlign = SU - UsedSteps;
  logic signed [33:0] dc_q [CAlign];
  logic signed [33:0] ds_q [CAlign];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dc_q[0] <= cf_q[UsedSteps-1] ? -cx_q[UsedSteps-1] : cx_q[UsedSteps-1];
      ds_q[0] <= cf_q[UsedSteps-1] ? -cy_q[UsedSteps-1] : cy_q[UsedSteps-1];
      for (int i = 1; i < CAlign; i++) begin
        dc_q[i] <= dc_q[i-1];
        ds_q[i] <= ds_q[i-1];
      end
    end
  end

  // back stages: unit axis, t*u and s*u; then matrix; then dot products
  logic signed [33:0] u_q [3];
  logic signed [33:0] tu_q [3];
  logic signed [33:0] su_q [3];
  logic signed [33:0] c1_q;
  logic signed [33:0] m_q [3][3];
  item_t              it1_q, it2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      begin
        logic signed [33:0] uu [3];
        logic signed [33:0] c, sn, t;
        c  = dc_q[CAlign-1];
        sn = ds_q[CAlign-1];
        t  = OneQ30 - c;
        for (int a = 0; a < 3; a++) begin
          logic [31:0] q;
          q = st_q[SU-1].quo[a];
          if (q > 32'(OneQ30)) q = 32'(OneQ30);
          uu[a] = st_q[SU-1].neg[a] ? -34'(q) : 34'(q);
          u_q[a]  <= uu[a];
          tu_q[a] <= mul_q30(t, uu[a]);
          su_q[a] <= mul_q30(sn, uu[a]);
        end
        c1_q  <= c;
        it1_q <= st_q[SU-1].it;
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          logic signed [34:0] e;
          e = 35'(mul_q30(tu_q[i], u_q[j]));
          if (i == j) e = e + 35'(c1_q);
          if (i == 0 && j == 1) e = e + 35'(su_q[2]);
          if (i == 0 && j == 2) e = e - 35'(su_q[1]);
          if (i == 1 && j == 0) e = e - 35'(su_q[2]);
          if (i == 1 && j == 2) e = e + 35'(su_q[0]);
          if (i == 2 && j == 0) e = e + 35'(su_q[1]);
          if (i == 2 && j == 1) e = e - 35'(su_q[0]);
          m_q[i][j] <= clamp_one(e);
        end
      end
      it2_q <= it1_q;
    end
  end

  logic vld_q [2];
  logic signed [31:0] r_d [3];
  logic [1:0] s_d;
  always_comb begin
    logic signed [31:0] vv [3];
    vv[0] = it2_q.vec_x; vv[1] = it2_q.vec_y; vv[2] = it2_q.vec_z;
    s_d = it2_q.zero_axis ? StatusZero : StatusOk;
    for (int i = 0; i < 3; i++) begin
      logic signed [67:0] acc, r;
      acc = 68'sd536870912;
      for (int j = 0; j < 3; j++) acc = acc + 68'(m_q[i][j]) * 68'(vv[j]);
      r = acc >>> 30;
      if (it2_q.zero_axis) r_d[i] = vv[i];
      else if (r > 68'sd2147483647) begin r_d[i] = 32'h7fffffff; s_d = StatusSat; end
      else if (r < -68'sd2147483648) begin r_d[i] = 32'h80000000; s_d = StatusSat; end
      else r_d[i] = 32'(r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SU; s++) st_q[s] <= '0;
      for (int i = 0; i < 2; i++) vld_q[i] <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      for (int s = 0; s < SU; s++) st_q[s] <= st_d[s];
      vld_q[0] <= st_q[SU-1].vld;
      vld_q[1] <= vld_q[0];
      ov_q     <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld_q[1]) begin
      rx_q <= r_d[0];
      ry_q <= r_d[1];
      rz_q <= r_d[2];
      rs_q <= s_d;
    end
  end

  assign out_valid = ov_q;
  assign rot_x_o   = rx_q;
  assign rot_y_o   = ry_q;
  assign rot_z_o   = rz_q;
  assign status_o  = rs_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready) |=> ov_q) else $error("result dropped while stalled");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready) |-> !q_ready_o) else $error("overrun");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (rs_q != 2'd3)) else $error("bad status");

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import aavr_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         st;
  } rot_t;

  localparam longint OneQ = 64'sd1073741824;
  localparam longint HalfQ = 64'sd536870912;
  localparam int IdleLimit = 3000;
  localparam longint AtanTab [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic signed [31:0] axis_x_i = '0, axis_y_i = '0, axis_z_i = '0;
  logic [15:0] angle_phase_i = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] rot_x_o, rot_y_o, rot_z_o;
  logic [1:0] status_o;

  rot_t expected_rot[$];
  int fail_count = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;
  bit no_idle = 1'b0;

  axis_angle_vector_rotate u_top (
    .clk_i, .rst_ni, .in_valid, .in_ready,
    .vec_x_i, .vec_y_i, .vec_z_i, .axis_x_i, .axis_y_i, .axis_z_i, .angle_phase_i,
    .out_valid, .out_ready, .rot_x_o, .rot_y_o, .rot_z_o, .status_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint q30_product(longint a, longint b);
    return (a * b + HalfQ) >>> 30;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > OneQ) return OneQ;
    if (v < -OneQ) return -OneQ;
    return v;
  endfunction

  function automatic rot_t rotate_vector(logic signed [31:0] vx, vy, vz, ax, ay, az,
                                         logic [15:0] ph);
    longint v[3], a[3], u[3], m[3][3];
    longint unsigned mg[3], big, sum, len, q, rem, root, bt;
    longint c, s, t, x, y, z, dx, dy, p, acc, r, tu, sx, sy, sz;
    int k;
    bit flip;
    rot_t res;
    v[0] = vx; v[1] = vy; v[2] = vz;
    a[0] = ax; a[1] = ay; a[2] = az;
    for (int i = 0; i < 3; i++) mg[i] = (a[i] < 0) ? longint'(-a[i]) : longint'(a[i]);
    big = mg[0];
    if (mg[1] > big) big = mg[1];
    if (mg[2] > big) big = mg[2];
    if (big == 0) begin
      res.x = vx; res.y = vy; res.z = vz; res.st = StatusZero;
      return res;
    end
    k = 0;
    while ((big << k) < (64'd1 << 30)) k++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = mg[i] << k;
      sum += mg[i] * mg[i];
    end
    rem = sum; root = 0; bt = 64'd1 << 62;
    while (bt > rem) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= root + bt) begin
        rem -= root + bt;
        root = (root >> 1) + bt;
      end else begin
        root = root >> 1;
      end
      bt = bt >> 2;
    end
    len = root;
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << 30) + (len >> 1)) / len;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      u[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
    end
    p = ph;
    flip = 1'b0;
    if (p >= 32768) p -= 65536;
    if (p > 16384) begin
      p -= 32768; flip = 1'b1;
    end else if (p < -16384) begin
      p += 32768; flip = 1'b1;
    end
    z = p * 65536;
    x = CordicGain;
    y = 0;
    for (int i = 0; i < UsedSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    t = OneQ - c;
    for (int i = 0; i < 3; i++) begin
      tu = q30_product(t, u[i]);
      for (int j = 0; j < 3; j++) m[i][j] = q30_product(tu, u[j]);
      m[i][i] += c;
    end
    sx = q30_product(s, u[0]); sy = q30_product(s, u[1]); sz = q30_product(s, u[2]);
    m[0][1] += sz; m[0][2] -= sy;
    m[1][0] -= sz; m[1][2] += sx;
    m[2][0] += sy; m[2][1] -= sx;
    res.st = StatusOk;
    for (int i = 0; i < 3; i++) begin
      acc = HalfQ;
      for (int j = 0; j < 3; j++) acc += clamp_unit(m[i][j]) * v[j];
      r = acc >>> 30;
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647; res.st = StatusSat;
      end else if (r < -64'sd2147483648) begin
        r = -64'sd2147483648; res.st = StatusSat;
      end
      if (i == 0) res.x = r[31:0];
      else if (i == 1) res.y = r[31:0];
      else res.z = r[31:0];
    end
    return res;
  endfunction

  // record an expectation per accepted input transaction, check each accepted result against it
  always @(posedge clk_i) begin
    rot_t e;
    if (rst_ni && in_valid && in_ready)
      expected_rot.push_back(rotate_vector(vec_x_i, vec_y_i, vec_z_i, axis_x_i, axis_y_i,
                                           axis_z_i, angle_phase_i));
    if (rst_ni && out_valid && out_ready) begin
      if (expected_rot.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        e = expected_rot.pop_front();
        if (rot_x_o !== e.x) begin
          $error("rot_x expected %0d actual %0d", e.x, rot_x_o); fail_count++;
        end
        if (rot_y_o !== e.y) begin
          $error("rot_y expected %0d actual %0d", e.y, rot_y_o); fail_count++;
        end
        if (rot_z_o !== e.z) begin
          $error("rot_z expected %0d actual %0d", e.z, rot_z_o); fail_count++;
        end
        if (status_o !== e.st) begin
          $error("status expected %0d actual %0d", e.st, status_o); fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // receiver
  initial begin
    int gap;
    gap = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 25)
          gap = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
      end
    end
  end

  task automatic send_rotation(logic signed [31:0] vx, vy, vz, ax, ay, az,
                               logic [15:0] ph, int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    vec_x_i <= vx; vec_y_i <= vy; vec_z_i <= vz;
    axis_x_i <= ax; axis_y_i <= ay; axis_z_i <= az;
    angle_phase_i <= ph;
    do @(posedge clk_i); while (!in_ready);
  endtask

  function automatic int pick_gap();
    if (no_idle || $urandom_range(0, 99) < 70) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 50);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic signed [31:0] pick_value(int sel);
    case (sel)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 32'h3fff_ffff)) - 32'sh2000_0000;
    endcase
  endfunction

  task automatic idle_until_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (expected_rot.size() == 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic signed [31:0] mx, mn;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    send_rotation(mx, mn, 5, 0, 0, 0, 16'd1234, 0);
    send_rotation(mn, mx, -1, 0, 0, 0, 16'd0, 0);
    send_rotation(32'sh10000, 0, 0, 0, 0, 32'sh10000, 16'd0, 0);
    send_rotation(32'sh10000, 0, 0, 0, 0, 32'sh10000, 16'd16384, 0);
    send_rotation(32'sh10000, 0, 0, 0, 0, 32'sh10000, 16'd32768, 1);
    send_rotation(32'sh10000, 0, 0, 0, 0, 32'sh10000, 16'd49152, 0);
    send_rotation(32'sh10000, 32'sh20000, 0, 1, 0, 0, 16'd65535, 0);
    send_rotation(32'sh10000, 32'sh20000, 7, 0, 1, 0, 16'd16385, 2);
    send_rotation(3, 4, 5, mn, 0, 0, 16'd16383, 0);
    send_rotation(3, 4, 5, mx, mx, mx, 16'd32767, 0);
    send_rotation(3, 4, 5, mn, mn, mn, 16'd32769, 0);
    send_rotation(mn, 0, 0, 0, 0, 1, 16'd32768, 0);
    send_rotation(mx, mx, mx, 1, 1, 1, 16'd32768, 0);
    send_rotation(mn, mn, mn, 1, -1, 1, 16'd21845, 0);
    send_rotation(mx, mn, mx, 0, 1, 1, 16'd8192, 0);
    send_rotation(mx, mx, 0, 0, 0, 1, 16'd8192, 0);
    send_rotation(-1, -1, -1, -1, -1, -1, 16'd49151, 0);
    send_rotation(32'sh12345, -32'sh6789, 32'sh1111, 5, -7, 3, 16'd49153, 0);
    idle_until_drained();
  endtask

  task automatic send_random_rotation(int gap);
    logic signed [31:0] ax, ay, az;
    int r;
    r = $urandom_range(0, 99);
    ax = pick_value($urandom_range(0, 3));
    ay = pick_value($urandom_range(0, 3));
    az = pick_value($urandom_range(0, 3));
    if (r < 4) begin
      ax = 0; ay = 0; az = 0;
    end else if (r < 12) begin
      ay = 0; az = 0;
    end
    send_rotation(pick_value($urandom_range(0, 3)), pick_value($urandom_range(0, 3)),
                  pick_value($urandom_range(0, 3)), ax, ay, az, 16'($urandom), gap);
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 200 == 0) no_idle = ($urandom_range(0, 2) == 0);
      send_random_rotation(pick_gap());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    for (int n = 0; n < 40; n++) send_random_rotation(0);
  endtask

  task automatic test_drain_pause();
    for (int n = 0; n < 30; n++) send_random_rotation(pick_gap());
    idle_until_drained();
    for (int n = 0; n < 30; n++) send_random_rotation(0);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(800);
    test_backpressure();
    test_drain_pause();
    test_random(800);
    idle_until_drained();
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
